/* design/assert_macros.svh */
// assertion macros shared by the probe modules
// depends on nothing; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define CHK_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/chsp_pkg.sv */
// types and constants of the closest surface height probe
// no dependencies; imported by the controller, datapath and top level
package chsp_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_UP_X       = 3'd0;
  localparam logic [2:0] CFG_UP_Y       = 3'd1;
  localparam logic [2:0] CFG_UP_Z       = 3'd2;
  localparam logic [2:0] CFG_MEAN_LEVEL = 3'd3;
  localparam logic [2:0] CFG_BASE_RAD   = 3'd4;

  // reset values
  localparam logic signed [15:0] UP_Z_RST   = 16'sd16384;
  localparam logic [26:0]        R8_RST     = 27'd2560;     // (10 * 65536) >> 8
  localparam logic [53:0]        BEST_RST   = 54'd6553600;  // R8_RST squared
  localparam logic signed [51:0] ROUND_HALF = 52'sd8192;    // half of 2^14
  localparam int                 HEIGHT_SHIFT = 14;
  localparam int                 MAG_SHIFT    = 22;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_CROSS,
    S_MAG,
    S_SQ,
    S_CMP,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ld_start;  // start transaction: load gauge, clear search
    logic ld_node;   // node transaction: capture node
    logic upd;       // compare and update the nearest node
    logic emit;      // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // captured node ends the scan
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

/* design/chsp_ctrl.sv */
// controller state machine of the closest surface height probe
// depends on chsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module chsp_ctrl
  import chsp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_action,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_action) state_nxt = S_PROD;
      end
      S_PROD:  state_nxt = S_CROSS;
      S_CROSS: state_nxt = S_MAG;
      S_MAG:   state_nxt = S_SQ;
      S_SQ:    state_nxt = S_CMP;
      S_CMP: begin
        state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = (state_r == S_IDLE);
    cmd.ld_start = (state_r == S_IDLE) && in_tvalid && !in_action;
    cmd.ld_node  = (state_r == S_IDLE) && in_tvalid && in_action;
    cmd.upd      = (state_r == S_CMP);
    cmd.emit     = (state_r == S_EMIT) && sts.out_free;
  end

  `CHK_NEXT(a_node_starts_scan, clk, rst_n, cmd.ld_node, state_r == S_PROD)
  `CHK_NEXT(a_emit_returns_idle, clk, rst_n, cmd.emit, state_r == S_IDLE)
  `CHK_NOW(a_one_load_at_a_time, clk, rst_n, cmd.ld_node || cmd.ld_start, !cmd.upd && !cmd.emit)

endmodule

/* design/chsp_dpath.sv */
// datapath of the closest surface height probe: config, offsets, cross
// product, squared distance, height and result register; depends on chsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module chsp_dpath
  import chsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input payload
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic        isolated,
  input  logic        rigid,
  input  logic        surf_node,
  input  logic        last_node,
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic signed [31:0] surf_height,
  output logic        found,
  // control
  input  cmd_t        cmd,
  output sts_t        sts
);

  // configuration registers
  logic signed [15:0] up_x_r, up_y_r, up_z_r;
  logic signed [31:0] mean_r;
  logic [26:0]        r8_r;
  logic [34:0]        rad10;

  // search state
  logic signed [31:0] gauge_x_r, gauge_y_r, gauge_z_r;
  logic [53:0]        best_d2_r;
  logic signed [31:0] best_h_r;
  logic               found_r;

  // captured node
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [32:0] rx_r, ry_r, rz_r;
  logic               qual_r, last_r;

  // pipeline
  logic signed [48:0] p_yz_r, p_zy_r, p_zx_r, p_xz_r, p_xy_r, p_yx_r;
  logic signed [47:0] hx_r, hy_r, hz_r;
  logic signed [49:0] c0_r, c1_r, c2_r, hsum_r;
  logic [49:0]        a0, a1, a2;
  logic [27:0]        m0_r, m1_r, m2_r;
  logic               in_rng_r;
  logic signed [51:0] h_rnd, h_diff;
  logic signed [31:0] h_sat, h_r;
  logic [55:0]        sq0_r, sq1_r, sq2_r;
  logic [57:0]        d2;
  logic               take;

  // result register
  logic               out_valid_r;
  logic signed [31:0] out_h_r;
  logic               out_f_r;

  // ten times the base radius, in the format of cfg_data; bits 34:8 give r8_r in Q.8
  assign rad10 = {1'b0, cfg_data[30:0], 3'b000} + {3'b000, cfg_data[30:0], 1'b0};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= '0;
      up_y_r <= '0;
      up_z_r <= UP_Z_RST;
      mean_r <= '0;
      r8_r   <= R8_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UP_X:       up_x_r <= cfg_data[15:0];
        CFG_UP_Y:       up_y_r <= cfg_data[15:0];
        CFG_UP_Z:       up_z_r <= cfg_data[15:0];
        CFG_MEAN_LEVEL: mean_r <= cfg_data;
        CFG_BASE_RAD:   r8_r   <= rad10[34:8];
        default: ;
      endcase
    end
  end

  assign d2   = {2'b00, sq0_r} + {2'b00, sq1_r} + {2'b00, sq2_r};
  assign take = qual_r && in_rng_r && (d2 < {4'b0000, best_d2_r});

  // search state: start clears, compare stage keeps the strictly nearest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gauge_x_r <= '0;
      gauge_y_r <= '0;
      gauge_z_r <= '0;
      best_d2_r <= BEST_RST;
      best_h_r  <= '0;
      found_r   <= 1'b0;
    end else if (cmd.ld_start) begin
      gauge_x_r <= pos_x;
      gauge_y_r <= pos_y;
      gauge_z_r <= pos_z;
      best_d2_r <= r8_r * r8_r;
      best_h_r  <= '0;
      found_r   <= 1'b0;
    end else if (cmd.upd && take) begin
      best_d2_r <= d2[53:0];
      best_h_r  <= h_r;
      found_r   <= 1'b1;
    end
  end

  // node capture with offsets from the gauge
  always_ff @(posedge clk) begin
    if (cmd.ld_node) begin
      px_r   <= pos_x;
      py_r   <= pos_y;
      pz_r   <= pos_z;
      rx_r   <= 33'(pos_x) - 33'(gauge_x_r);
      ry_r   <= 33'(pos_y) - 33'(gauge_y_r);
      rz_r   <= 33'(pos_z) - 33'(gauge_z_r);
      qual_r <= !isolated && !rigid && surf_node;
      last_r <= last_node;
    end
  end

  // magnitudes and rounded, saturated height
  assign a0 = c0_r[49] ? 50'(-c0_r) : 50'(c0_r);
  assign a1 = c1_r[49] ? 50'(-c1_r) : 50'(c1_r);
  assign a2 = c2_r[49] ? 50'(-c2_r) : 50'(c2_r);
  assign h_rnd  = (52'(hsum_r) + ROUND_HALF) >>> HEIGHT_SHIFT;
  assign h_diff = h_rnd - 52'(mean_r);

  always_comb begin
    if (h_diff > 52'sd2147483647) begin
      h_sat = 32'sh7FFFFFFF;
    end else if (h_diff < -52'sd2147483648) begin
      h_sat = 32'sh80000000;
    end else begin
      h_sat = h_diff[31:0];
    end
  end

  // stage registers without enables; the controller sequence picks when each is used
  always_ff @(posedge clk) begin
    // products
    p_yz_r <= up_y_r * rz_r;
    p_zy_r <= up_z_r * ry_r;
    p_zx_r <= up_z_r * rx_r;
    p_xz_r <= up_x_r * rz_r;
    p_xy_r <= up_x_r * ry_r;
    p_yx_r <= up_y_r * rx_r;
    hx_r   <= up_x_r * px_r;
    hy_r   <= up_y_r * py_r;
    hz_r   <= up_z_r * pz_r;
    // cross product and height sum
    c0_r   <= 50'(p_yz_r) - 50'(p_zy_r);
    c1_r   <= 50'(p_zx_r) - 50'(p_xz_r);
    c2_r   <= 50'(p_xy_r) - 50'(p_yx_r);
    hsum_r <= 50'(hx_r) + 50'(hy_r) + 50'(hz_r);
    // Q.8 magnitudes and range check
    m0_r     <= a0[MAG_SHIFT +: 28];
    m1_r     <= a1[MAG_SHIFT +: 28];
    m2_r     <= a2[MAG_SHIFT +: 28];
    in_rng_r <= (a0[MAG_SHIFT +: 28] < {1'b0, r8_r}) &&
                (a1[MAG_SHIFT +: 28] < {1'b0, r8_r}) &&
                (a2[MAG_SHIFT +: 28] < {1'b0, r8_r});
    h_r      <= h_sat;
    // squares
    sq0_r <= m0_r * m0_r;
    sq1_r <= m1_r * m1_r;
    sq2_r <= m2_r * m2_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_h_r <= found_r ? best_h_r : '0;
      out_f_r <= found_r;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign surf_height = out_h_r;
  assign found       = out_f_r;

  // status to the controller
  always_comb begin
    sts.last     = last_r;
    sts.out_free = !out_valid_r || out_tready;
  end

  `CHK_NOW(a_no_height_without_find, clk, rst_n, !found_r, best_h_r == 32'sd0)
  `CHK_NOW(a_emit_into_free_slot, clk, rst_n, cmd.emit, !out_valid_r || out_tready)
  `CHK_NEXT(a_emit_shows_result, clk, rst_n, cmd.emit, out_valid_r && (out_f_r == $past(found_r)))

endmodule

/* design/closest_surface_height_probe.sv */
// Closest surface height probe: finds the free-surface node horizontally
// nearest to a gauge point and reports its height above the mean level.
// Input stream: in_tuser = 0 is a start transaction (gauge point in pos
// fields), in_tuser = 1 is a node; in_tlast marks the last node of a scan.
// Only a node that is not isolated, not rigid and on the free surface counts.
// Result stream: one transaction per last node, surf_height and found.
// Config channel: cfg_index selects up_dir_x/y/z, mean_level, base_radius;
// always ready, to be written only while the block is idle.
// Sequencing: start transactions are accepted back to back; the sequencer walks
// each node through product, cross, magnitude, square and compare before the
// next item is accepted, and a last node also through emit, which holds until
// the result slot is free. The emit step loads the result register onto out_tvalid.
// A result waits in an output register; the next items are accepted while
// it waits, and only a further last node holds until the slot is free.
// Reset (rst_n low, synchronous): config to its reset values, gauge at the
// origin, search cleared with the default radius, result register empty.
// depends on chsp_pkg, chsp_ctrl and chsp_dpath
module closest_surface_height_probe
  import chsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // pos_x, pos_y, pos_z, isolated, rigid, surf_node, pad
  input  logic         in_tuser,  // action
  input  logic         in_tlast,  // last_node
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata, // surf_height, found, pad
  // configuration
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  cmd_t               cmd;
  sts_t               sts;
  logic signed [31:0] surf_height;
  logic               found;

  assign cfg_ready = 1'b1;

  chsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  chsp_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pos_x        (in_tdata[31:0]),
    .pos_y        (in_tdata[63:32]),
    .pos_z        (in_tdata[95:64]),
    .isolated     (in_tdata[96]),
    .rigid        (in_tdata[97]),
    .surf_node    (in_tdata[98]),
    .last_node    (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .surf_height  (surf_height),
    .found        (found),
    .cmd          (cmd),
    .sts          (sts)
  );

  // pack the result fields
  assign out_tdata = {7'b0000000, found, surf_height};

endmodule
